// ----- rtl/core/timed_position_history_rewind_assert.svh -----
// Assertion macros used by the RTL.
`ifndef TIMED_POSITION_HISTORY_REWIND_ASSERT_SVH
`define TIMED_POSITION_HISTORY_REWIND_ASSERT_SVH
`ifndef SYNTHESIS
`define TPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/tph_pkg.sv -----
package tph_pkg;

  localparam int COORDS    = 9;
  localparam int COORD_W   = 24;
  localparam int TIME_W    = 31;
  localparam int FRAC_W    = 17;
  localparam int PERIOD_W  = 10;

  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 10'd50;

  localparam logic [1:0] OP_STORE  = 2'd0;
  localparam logic [1:0] OP_REWIND = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [TIME_W-1:0] tstamp_t;
  typedef logic [COORDS-1:0][COORD_W-1:0] box_t;

  typedef struct packed {
    logic [1:0] op;
    tstamp_t    req_time;
    tstamp_t    now_time;
    coord_t     origin_x;
    coord_t     origin_y;
    coord_t     origin_z;
    coord_t     min_x;
    coord_t     min_y;
    coord_t     min_z;
    coord_t     max_x;
    coord_t     max_y;
    coord_t     max_z;
  } in_item_t;

  typedef struct packed {
    logic   adjusted;
    coord_t out_origin_x;
    coord_t out_origin_y;
    coord_t out_origin_z;
    coord_t out_min_x;
    coord_t out_min_y;
    coord_t out_min_z;
    coord_t out_max_x;
    coord_t out_max_y;
    coord_t out_max_z;
  } out_item_t;

  typedef struct packed {
    logic    en;
    tstamp_t tstamp;
    box_t    box;
  } hist_wr_t;

  function automatic box_t item_box(input in_item_t it);
    box_t b;
    b[0] = it.origin_x;
    b[1] = it.origin_y;
    b[2] = it.origin_z;
    b[3] = it.min_x;
    b[4] = it.min_y;
    b[5] = it.min_z;
    b[6] = it.max_x;
    b[7] = it.max_y;
    b[8] = it.max_z;
    return b;
  endfunction

endpackage

// ----- rtl/core/tph_if.sv -----
interface tph_in_if;
  import tph_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tph_out_if;
  import tph_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/timed_position_history_rewind.sv -----
// Timestamped box history with rewind lookup.
// in_ch carries one item per command: op 0 stores the box at now_time in the
// next ring slot, op 2 seeds every slot with the box at times spaced by the
// frame period, and op 1 looks up the box at min(req_time, now_time).
// out_ch returns exactly one item per command: the interpolated past box
// with adjusted set, or the input box with adjusted clear.
// cfg_we and cfg_wdata write the frame period; zero acts as 50 ms.
// A rewind walks back from the newest slot, then interpolates with the
// bit-serial divider and the multiplier that all coordinates share.
// in_ch.ready is high only while idle.
// A finished item waits in the output register while the receiver stalls.
// The next command is accepted meanwhile, but its result holds the sequencer
// in its last state until the register has been delivered.
// After reset all slots read as time zero with a zero box, the newest slot is
// the last one, and the period is 50 ms.
module timed_position_history_rewind #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tph_in_if.sink                      in_ch,
  tph_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [tph_pkg::PERIOD_W-1:0] cfg_wdata
);
  import tph_pkg::*;
`include "timed_position_history_rewind_assert.svh"

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(HISTORY_DEPTH - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STORE = 4'd1;
  localparam logic [3:0] S_SEED  = 4'd2;
  localparam logic [3:0] S_WRD   = 4'd3;
  localparam logic [3:0] S_WCMP  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_CRD   = 4'd6;
  localparam logic [3:0] S_LMUL  = 4'd7;
  localparam logic [3:0] S_LADD  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]          state_r;
  logic [PERIOD_W-1:0] period_r;
  logic [SLOT_W-1:0]   newest_r, top_r, i_r, j_r, s_r;
  logic [SLOT_W-1:0]   newer_slot, older_i;
  tstamp_t             tq_r, now_r, tj_r, seed_r;
  box_t                box_r, res_r;
  logic                adj_r;
  logic [FRAC_W-1:0]   frac_r;
  logic [3:0]          k_r;
  logic signed [42:0]  prod_r;
  out_item_t           out_data_r;
  logic                out_valid_r;

  hist_wr_t            wr;
  logic [SLOT_W-1:0]   wr_addr;
  tstamp_t             t_rdata;
  box_t                a_rdata, b_rdata;
  logic                div_start, div_done;
  tstamp_t             div_num, div_den;
  logic [FRAC_W-1:0]   quot;

  logic [PERIOD_W-1:0] period_eff;
  logic signed [24:0]  diff;
  logic signed [26:0]  sum;
  logic                accept;
  in_item_t            it;

  assign it         = in_ch.data;
  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign newer_slot = (newest_r == LAST) ? '0 : newest_r + 1'b1;
  assign older_i    = (i_r == '0) ? LAST : i_r - 1'b1;
  assign period_eff = (period_r == '0) ? DEFAULT_PERIOD : period_r;

  always_comb begin
    wr.en     = (state_r == S_STORE) || (state_r == S_SEED);
    wr.tstamp = (state_r == S_STORE) ? now_r : seed_r;
    wr.box    = box_r;
    wr_addr   = (state_r == S_STORE) ? newer_slot : s_r;
    div_start = (state_r == S_WCMP) && (t_rdata <= tq_r) && (i_r != j_r);
    div_num   = tj_r - tq_r;
    div_den   = tj_r - t_rdata;
    diff = 25'($signed(b_rdata[k_r])) - 25'($signed(a_rdata[k_r]));
    sum  = 27'($signed(a_rdata[k_r])) + prod_r[42:16];
  end

  tph_hist #(.DEPTH(HISTORY_DEPTH)) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .wr_addr (wr_addr),
    .t_addr  (i_r),
    .a_addr  (j_r),
    .b_addr  (i_r),
    .t_rdata (t_rdata),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata)
  );

  tph_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= DEFAULT_PERIOD;
      newest_r    <= LAST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (it.op)
              OP_STORE:  state_r <= S_STORE;
              OP_REWIND: state_r <= S_WRD;
              OP_RESET: begin
                state_r  <= S_SEED;
                newest_r <= LAST;
              end
              default:   state_r <= S_DONE;
            endcase
          end
        end
        S_STORE: begin
          newest_r <= newer_slot;
          state_r  <= S_DONE;
        end
        S_SEED: begin
          if (s_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_WRD: state_r <= S_WCMP;
        S_WCMP: begin
          if (t_rdata <= tq_r) begin
            state_r <= (i_r == j_r) ? S_DONE : S_DIV;
          end else if (older_i == top_r) begin
            state_r <= S_CRD;
          end else begin
            state_r <= S_WRD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_CRD;
          end
        end
        S_CRD: state_r <= S_LMUL;
        S_LMUL: state_r <= S_LADD;
        S_LADD: state_r <= (k_r == 4'(COORDS - 1)) ? S_DONE : S_LMUL;
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          tq_r       <= (it.req_time > it.now_time) ? it.now_time : it.req_time;
          now_r      <= it.now_time;
          seed_r     <= it.now_time;
          box_r      <= item_box(it);
          res_r      <= item_box(it);
          adj_r      <= 1'b0;
          top_r      <= newest_r;
          i_r        <= newest_r;
          j_r        <= newest_r;
          s_r        <= LAST;
          k_r        <= '0;
        end
      end
      S_SEED: begin
        s_r    <= s_r - 1'b1;
        seed_r <= (seed_r >= TIME_W'(period_eff)) ? seed_r - TIME_W'(period_eff) : '0;
      end
      S_WCMP: begin
        if (t_rdata > tq_r) begin
          j_r  <= i_r;
          tj_r <= t_rdata;
          if (older_i == top_r) begin
            // Every slot is newer: a zero fraction returns the oldest box.
            frac_r <= '0;
          end else begin
            i_r <= older_i;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          frac_r <= quot;
        end
      end
      S_CRD: begin
        adj_r <= 1'b1;
      end
      S_LMUL: prod_r <= diff * $signed({1'b0, frac_r});
      S_LADD: begin
        res_r[k_r] <= sum[COORD_W-1:0];
        k_r        <= k_r + 4'd1;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_data_r.adjusted     <= adj_r;
          out_data_r.out_origin_x <= res_r[0];
          out_data_r.out_origin_y <= res_r[1];
          out_data_r.out_origin_z <= res_r[2];
          out_data_r.out_min_x    <= res_r[3];
          out_data_r.out_min_y    <= res_r[4];
          out_data_r.out_min_z    <= res_r[5];
          out_data_r.out_max_x    <= res_r[6];
          out_data_r.out_max_y    <= res_r[7];
          out_data_r.out_max_z    <= res_r[8];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `TPH_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, state_r != S_IDLE)
  `TPH_ASSERT_IMP(a_div_in_wait, clk, rst_n, div_done, state_r == S_DIV)
  `TPH_ASSERT_IMP(a_newest_range, clk, rst_n, 1'b1, newest_r <= LAST)

endmodule

// ----- rtl/core/tph_hist.sv -----
module tph_hist #(
  parameter int DEPTH = 16,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tph_pkg::hist_wr_t wr,
  input  logic [AW-1:0]    wr_addr,
  input  logic [AW-1:0]    t_addr,
  input  logic [AW-1:0]    a_addr,
  input  logic [AW-1:0]    b_addr,
  output tph_pkg::tstamp_t t_rdata,
  output tph_pkg::box_t    a_rdata,
  output tph_pkg::box_t    b_rdata
);
  import tph_pkg::*;

  tstamp_t          tmem [DEPTH];
  box_t             cmem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  tstamp_t          t_q_r;
  box_t             a_q_r;
  box_t             b_q_r;
  logic             t_v_r;
  logic             a_v_r;
  logic             b_v_r;

  // Rows never written read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tmem[wr_addr] <= wr.tstamp;
      cmem[wr_addr] <= wr.box;
    end
    t_q_r <= tmem[t_addr];
    a_q_r <= cmem[a_addr];
    b_q_r <= cmem[b_addr];
    t_v_r <= vld_r[t_addr];
    a_v_r <= vld_r[a_addr];
    b_v_r <= vld_r[b_addr];
  end

  assign t_rdata = t_v_r ? t_q_r : '0;
  assign a_rdata = a_v_r ? a_q_r : '0;
  assign b_rdata = b_v_r ? b_q_r : '0;

endmodule

// ----- rtl/core/tph_div.sv -----
module tph_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  tph_pkg::tstamp_t          dividend,
  input  tph_pkg::tstamp_t          divisor,
  output logic                      done,
  output logic [tph_pkg::FRAC_W-1:0] quot
);
  import tph_pkg::*;

  // Restoring division, one quotient bit per cycle, integer bit first.
  logic [TIME_W:0]   rem_r, rem_nxt;
  tstamp_t           den_r;
  logic [FRAC_W-1:0] q_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [TIME_W:0]   trial;
  logic              ge;

  always_comb begin
    trial = (cnt_r == 5'(FRAC_W)) ? rem_r : {rem_r[TIME_W-1:0], 1'b0};
    ge = trial >= {1'b0, den_r};
    rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(FRAC_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      den_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[FRAC_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- sim/tb_timed_position_history_rewind.sv -----
module tb_timed_position_history_rewind;
  import tph_pkg::*;

  localparam int DEPTH = 16;

  class history_scoreboard;
    logic [PERIOD_W-1:0] period;
    int unsigned newest;
    tstamp_t times[DEPTH];
    coord_t coords[DEPTH][COORDS];
    out_item_t pending[$];
    int errors;

    function new();
      period = DEFAULT_PERIOD;
      newest = DEPTH - 1;
      errors = 0;
      for (int s = 0; s < DEPTH; s++) begin
        times[s] = '0;
        for (int k = 0; k < COORDS; k++) coords[s][k] = '0;
      end
    endfunction

    function automatic void note_item(in_item_t it);
      coord_t b[COORDS];
      coord_t r[COORDS];
      out_item_t o;
      logic adj;
      tstamp_t t;
      tstamp_t p;
      int unsigned i;
      int unsigned j;
      bit found;
      longint unsigned num;
      longint unsigned den;
      longint frac;
      longint a;
      longint bb;
      longint prod;
      longint q;
      b[0] = it.origin_x; b[1] = it.origin_y; b[2] = it.origin_z;
      b[3] = it.min_x; b[4] = it.min_y; b[5] = it.min_z;
      b[6] = it.max_x; b[7] = it.max_y; b[8] = it.max_z;
      r = b;
      adj = 1'b0;
      if (it.op == OP_STORE) begin
        newest = (newest + 1) % DEPTH;
        times[newest] = it.now_time;
        coords[newest] = b;
      end else if (it.op == OP_RESET) begin
        p = (period == 0) ? tstamp_t'(DEFAULT_PERIOD) : tstamp_t'(period);
        t = it.now_time;
        newest = DEPTH - 1;
        for (int s = DEPTH - 1; s >= 0; s--) begin
          times[s] = t;
          coords[s] = b;
          t = (t >= p) ? t - p : '0;
        end
      end else if (it.op == OP_REWIND) begin
        t = (it.req_time > it.now_time) ? it.now_time : it.req_time;
        i = newest;
        j = newest;
        found = 0;
        do begin
          if (times[i] <= t) begin
            found = 1;
            break;
          end
          j = i;
          i = (i > 0) ? i - 1 : DEPTH - 1;
        end while (i != newest);
        if (i != j) begin
          adj = 1'b1;
          if (found) begin
            num = longint'(times[j] - t) << 16;
            den = longint'(times[j] - times[i]);
            frac = longint'(num / den);
            for (int k = 0; k < COORDS; k++) begin
              a = coords[j][k];
              bb = coords[i][k];
              prod = (bb - a) * frac;
              q = (prod >= 0) ? (prod >>> 16) : -((-prod + 65535) >>> 16);
              r[k] = coord_t'(a + q);
            end
          end else begin
            r = coords[j];
          end
        end
      end
      o.adjusted = adj;
      o.out_origin_x = r[0]; o.out_origin_y = r[1]; o.out_origin_z = r[2];
      o.out_min_x = r[3]; o.out_min_y = r[4]; o.out_min_z = r[5];
      o.out_max_x = r[6]; o.out_max_y = r[7]; o.out_max_z = r[8];
      pending.push_back(o);
    endfunction

    function automatic void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.adjusted !== want.adjusted)
        $display("%0t adjusted: expected %0d, actual %0d", $time, want.adjusted, got.adjusted);
      if (got.out_origin_x !== want.out_origin_x)
        $display("%0t origin_x: expected %0d, actual %0d", $time,
                 want.out_origin_x, got.out_origin_x);
      if (got.out_origin_y !== want.out_origin_y)
        $display("%0t origin_y: expected %0d, actual %0d", $time,
                 want.out_origin_y, got.out_origin_y);
      if (got.out_origin_z !== want.out_origin_z)
        $display("%0t origin_z: expected %0d, actual %0d", $time,
                 want.out_origin_z, got.out_origin_z);
      if (got.out_min_x !== want.out_min_x)
        $display("%0t min_x: expected %0d, actual %0d", $time, want.out_min_x, got.out_min_x);
      if (got.out_min_y !== want.out_min_y)
        $display("%0t min_y: expected %0d, actual %0d", $time, want.out_min_y, got.out_min_y);
      if (got.out_min_z !== want.out_min_z)
        $display("%0t min_z: expected %0d, actual %0d", $time, want.out_min_z, got.out_min_z);
      if (got.out_max_x !== want.out_max_x)
        $display("%0t max_x: expected %0d, actual %0d", $time, want.out_max_x, got.out_max_x);
      if (got.out_max_y !== want.out_max_y)
        $display("%0t max_y: expected %0d, actual %0d", $time, want.out_max_y, got.out_max_y);
      if (got.out_max_z !== want.out_max_z)
        $display("%0t max_z: expected %0d, actual %0d", $time, want.out_max_z, got.out_max_z);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [PERIOD_W-1:0] cfg_wdata;
  tph_in_if in_ch();
  tph_out_if out_ch();
  history_scoreboard board;
  tstamp_t clock_ms;
  int long_hold;

  timed_position_history_rewind #(.HISTORY_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && cfg_we) board.period = cfg_wdata;
    if (rst_n && in_ch.valid && in_ch.ready) board.note_item(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_ch.ready <= 1'b0;
        long_hold--;
      end else begin
        case ($urandom_range(0, 3))
          0: out_ch.ready <= ($urandom_range(0, 3) == 0);
          1: out_ch.ready <= ($urandom_range(0, 1) == 0);
          default: out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(24'h7fffff);
      1: return coord_t'(24'h800000);
      2: return coord_t'($urandom_range(0, 2000) - 1000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send(logic [1:0] op, tstamp_t req, tstamp_t now, bit edge_box);
    in_item_t it;
    it.op = op;
    it.req_time = req;
    it.now_time = now;
    it.origin_x = rand_coord(); it.origin_y = rand_coord(); it.origin_z = rand_coord();
    it.min_x = rand_coord(); it.min_y = rand_coord(); it.min_z = rand_coord();
    it.max_x = rand_coord(); it.max_y = rand_coord(); it.max_z = rand_coord();
    if (edge_box) begin
      it.origin_x = coord_t'(24'h7fffff); it.min_x = coord_t'(24'h800000);
      it.max_x = coord_t'(24'h7fffff); it.origin_y = coord_t'(24'h800000);
    end
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int burst;
    int kind;
    tstamp_t req;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        pause();
        burst = $urandom_range(1, 20);
      end
      burst--;
      kind = $urandom_range(0, 19);
      if (clock_ms > 31'h7ff00000) clock_ms = tstamp_t'($urandom_range(0, 5000));
      if (kind < 8) begin
        clock_ms = clock_ms + tstamp_t'($urandom_range(0, 120));
        send(OP_STORE, tstamp_t'($urandom), clock_ms, 0);
      end else if (kind < 17) begin
        case ($urandom_range(0, 4))
          0: req = tstamp_t'($urandom);
          1: req = (clock_ms > 3000) ? clock_ms - tstamp_t'($urandom_range(0, 3000)) : '0;
          default: req = (clock_ms > 800) ? clock_ms - tstamp_t'($urandom_range(0, 800)) : '0;
        endcase
        send(OP_REWIND, req, clock_ms, 0);
      end else if (kind < 19) begin
        if ($urandom_range(0, 9) == 0) clock_ms = tstamp_t'($urandom);
        send(OP_RESET, tstamp_t'($urandom), clock_ms, 0);
      end else begin
        send(OP_NOP, tstamp_t'($urandom), tstamp_t'($urandom), 0);
      end
    end
  endtask

  initial begin
    board = new();
    long_hold = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    clock_ms = 1000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_REWIND, 31'd500, 31'd400, 0);
    send(OP_REWIND, 31'h7fffffff, 31'h7fffffff, 1);
    send(OP_STORE, 31'd0, 31'd100, 1);
    send(OP_STORE, 31'd0, 31'd200, 0);
    send(OP_REWIND, 31'd150, 31'd300, 0);
    send(OP_REWIND, 31'd250, 31'd200, 0);
    send(OP_RESET, 31'd0, 31'd120, 1);
    send(OP_REWIND, 31'd0, 31'd120, 0);
    send(OP_RESET, 31'd0, 31'h7fffffff, 0);
    send(OP_REWIND, 31'd0, 31'h7fffffff, 0);
    send(OP_REWIND, 31'h7fffffc0, 31'h7fffffff, 0);
    send(OP_NOP, 31'h7fffffff, 31'd0, 1);
    for (int s = 0; s < 17; s++) send(OP_STORE, 31'd0, tstamp_t'(2000 + 37 * s), 0);
    send(OP_REWIND, 31'd1000, 31'd5000, 0);
    send(OP_REWIND, 31'd2100, 31'd5000, 0);
    drain();

    write_period(10'd0);
    send(OP_RESET, 31'd0, 31'd300, 0);
    send(OP_REWIND, 31'd275, 31'd300, 0);
    drain();
    write_period(10'd1);
    send(OP_RESET, 31'd0, 31'd5, 0);
    send(OP_REWIND, 31'd0, 31'd5, 0);
    drain();

    write_period(10'd1000);
    random_phase(350);
    fork
      random_phase(150);
      begin
        repeat (20) @(posedge clk);
        long_hold = 400;
      end
    join
    drain();
    write_period(10'd1023);
    random_phase(300);
    drain();
    write_period(10'd7);
    random_phase(300);
    drain();
    write_period(10'($urandom_range(1, 1023)));
    random_phase(300);
    drain();
    write_period(10'($urandom_range(1, 1023)));
    random_phase(300);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
